>>> design/rsme_pkg.sv
// shared constants and codes for the register stack machine execute block
`default_nettype none

package rsme_pkg;

    // default sizes of the two stores
    localparam int STACK_DEPTH    = 16384;
    localparam int REGISTER_COUNT = 32;

    // data path width and width of the divider step counter
    localparam int DATA_W    = 32;
    localparam int DIV_CNT_W = $clog2(DATA_W);

    // opcodes
    localparam logic [7:0] OP_HALT    = 8'd0;
    localparam logic [7:0] OP_DISPLAY = 8'd1;
    localparam logic [7:0] OP_PRINT   = 8'd2;
    localparam logic [7:0] OP_PUSH    = 8'd10;
    localparam logic [7:0] OP_POP     = 8'd11;
    localparam logic [7:0] OP_MOV     = 8'd12;
    localparam logic [7:0] OP_STUB_LO = 8'd20;
    localparam logic [7:0] OP_STUB_HI = 8'd25;
    localparam logic [7:0] OP_ADD     = 8'd30;
    localparam logic [7:0] OP_SUB     = 8'd31;
    localparam logic [7:0] OP_MUL     = 8'd32;
    localparam logic [7:0] OP_DIV     = 8'd33;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_HALT    = 3'd1;
    localparam logic [2:0] ST_BADREG  = 3'd2;
    localparam logic [2:0] ST_BADOP   = 3'd3;
    localparam logic [2:0] ST_OVER    = 3'd4;
    localparam logic [2:0] ST_UNDER   = 3'd5;
    localparam logic [2:0] ST_DIVZ    = 3'd6;
    localparam logic [2:0] ST_IGNORED = 3'd7;

endpackage

`default_nettype wire

>>> design/rsme_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module rsme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/rsme_div.sv
// iterative signed divider, one quotient bit per cycle, truncates toward zero
`default_nettype none

module rsme_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [rsme_pkg::DATA_W-1:0] i_dividend,
    input  wire logic [rsme_pkg::DATA_W-1:0] i_divisor,
    output logic                            o_done,
    output logic      [rsme_pkg::DATA_W-1:0] o_quotient
);

    localparam int W  = rsme_pkg::DATA_W;
    localparam int CW = rsme_pkg::DIV_CNT_W;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_q;
    logic [W-1:0]  r_mb;
    logic          r_neg;

    logic          neg_a;
    logic          neg_b;
    logic [W:0]    shifted;
    logic [W+1:0]  diff;

    assign neg_a   = i_dividend[W-1];
    assign neg_b   = i_divisor[W-1];
    assign shifted = {r_rem, r_q[W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_mb};

    // restoring division on magnitudes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_q    <= neg_a ? (W'(0) - i_dividend) : i_dividend;
                r_mb   <= neg_b ? (W'(0) - i_divisor) : i_divisor;
                r_neg  <= neg_a ^ neg_b;
            end else if (r_busy) begin
                if (!diff[W+1]) begin
                    r_rem <= diff[W-1:0];
                end else begin
                    r_rem <= shifted[W-1:0];
                end
                r_q   <= {r_q[W-2:0], ~diff[W+1]};
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (W'(0) - r_q) : r_q;

endmodule

`default_nettype wire

>>> design/register_stack_machine_execute.sv
// each item passes the states S_IDLE (accept), S_EXEC and S_WB, with S_DIV between for DIV
// (the serial divider); S_WB commits once the output is free, and only then is a new item taken
// a finished result waits in the output register while the next item is taken
// reset clears the register file (per-entry valid bits), stack pointer and halt flag
// stack memory contents are not cleared; only pushed entries are ever read
`default_nettype none

module register_stack_machine_execute #(
    parameter int STACK_DEPTH    = rsme_pkg::STACK_DEPTH,
    parameter int REGISTER_COUNT = rsme_pkg::REGISTER_COUNT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // operation, reg_a, reg_b, immediate (from bit 0 up)
    input  wire logic [55:0] s_axis_tdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // status, display_register, display_value (from bit 0 up)
    output logic      [39:0] m_axis_tdata,
    // display_valid
    output logic             m_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready
);

    localparam int W   = rsme_pkg::DATA_W;
    localparam int RW  = $clog2(REGISTER_COUNT);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_WB
    } t_state;

    t_state r_state;

    // latched item
    logic [7:0]   r_op;
    logic [7:0]   r_ra;
    logic [7:0]   r_rb;
    logic [W-1:0] r_imm;
    logic         r_va_valid;
    logic         r_vb_valid;

    // architectural control state
    logic [REGISTER_COUNT-1:0] r_rf_valid;
    logic [SPW-1:0]            r_sp;
    logic                      r_halted;

    // pending commit
    logic [2:0]   r_status;
    logic         r_dvalid;
    logic [W-1:0] r_dval;
    logic [W-1:0] r_wdata;
    logic         r_rf_we;
    logic         r_st_we;
    logic         r_sp_dec;

    // output register
    logic         r_out_valid;
    logic [2:0]   r_out_status;
    logic         r_out_dvalid;
    logic [4:0]   r_out_dreg;
    logic [W-1:0] r_out_dval;

    // decode results
    logic [2:0]   n_status;
    logic         n_dvalid;
    logic [W-1:0] n_wdata;
    logic         n_rf_we;
    logic         n_st_we;
    logic         n_sp_dec;
    logic         n_div_start;

    logic         accept;
    logic         out_free;
    logic         commit;
    logic [7:0]   in_ra;
    logic [7:0]   in_rb;
    logic         in_ra_ok;
    logic         in_rb_ok;
    logic         ra_ok;
    logic         rb_ok;
    logic [W-1:0] rf_a_rdata;
    logic [W-1:0] rf_b_rdata;
    logic [W-1:0] st_rdata;
    logic [W-1:0] a_val;
    logic [W-1:0] b_val;
    logic         st_full;
    logic         st_empty;
    logic [SPW-1:0] sp_m1;
    logic         div_done;
    logic [W-1:0] div_q;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;
    assign commit   = (r_state == S_WB) && out_free;
    assign in_ra    = s_axis_tdata[15:8];
    assign in_rb    = s_axis_tdata[23:16];
    assign in_ra_ok = {1'b0, in_ra} < 9'(REGISTER_COUNT);
    assign in_rb_ok = {1'b0, in_rb} < 9'(REGISTER_COUNT);
    assign ra_ok    = {1'b0, r_ra} < 9'(REGISTER_COUNT);
    assign rb_ok    = {1'b0, r_rb} < 9'(REGISTER_COUNT);
    assign st_full  = r_sp == SPW'(STACK_DEPTH);
    assign st_empty = r_sp == '0;
    assign sp_m1    = r_sp - SPW'(1);
    assign a_val    = r_va_valid ? rf_a_rdata : '0;
    assign b_val    = r_vb_valid ? rf_b_rdata : '0;

    // register file, one copy per read port, written together
    rsme_ram #(
        .WIDTH (W),
        .DEPTH (REGISTER_COUNT)
    ) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (commit && r_rf_we),
        .i_waddr (r_ra[RW-1:0]),
        .i_wdata (r_wdata),
        .i_re    (accept),
        .i_raddr (in_ra[RW-1:0]),
        .o_rdata (rf_a_rdata)
    );

    rsme_ram #(
        .WIDTH (W),
        .DEPTH (REGISTER_COUNT)
    ) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (commit && r_rf_we),
        .i_waddr (r_ra[RW-1:0]),
        .i_wdata (r_wdata),
        .i_re    (accept),
        .i_raddr (in_rb[RW-1:0]),
        .o_rdata (rf_b_rdata)
    );

    // data stack, top entry read ahead for pop
    rsme_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (commit && r_st_we),
        .i_waddr (r_sp[SAW-1:0]),
        .i_wdata (r_wdata),
        .i_re    (accept),
        .i_raddr (sp_m1[SAW-1:0]),
        .o_rdata (st_rdata)
    );

    rsme_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_div_start),
        .i_dividend (a_val),
        .i_divisor  (b_val),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // decode and execute against the read data
    always_comb begin
        n_status    = rsme_pkg::ST_OK;
        n_dvalid    = 1'b0;
        n_wdata     = '0;
        n_rf_we     = 1'b0;
        n_st_we     = 1'b0;
        n_sp_dec    = 1'b0;
        n_div_start = 1'b0;
        if (r_state == S_EXEC) begin
            priority if (r_halted) begin
                n_status = rsme_pkg::ST_IGNORED;
            end else if (r_op == rsme_pkg::OP_HALT) begin
                n_status = rsme_pkg::ST_HALT;
            end else if (r_op == rsme_pkg::OP_DISPLAY) begin
                if (!ra_ok) begin
                    n_status = rsme_pkg::ST_BADREG;
                end else begin
                    n_dvalid = 1'b1;
                end
            end else if (r_op == rsme_pkg::OP_PRINT
                         || (r_op >= rsme_pkg::OP_STUB_LO && r_op <= rsme_pkg::OP_STUB_HI)) begin
                n_status = rsme_pkg::ST_OK;
            end else if (r_op == rsme_pkg::OP_PUSH) begin
                if (!ra_ok) begin
                    n_status = rsme_pkg::ST_BADREG;
                end else if (st_full) begin
                    n_status = rsme_pkg::ST_OVER;
                end else begin
                    n_wdata = a_val;
                    n_st_we = 1'b1;
                end
            end else if (r_op == rsme_pkg::OP_POP) begin
                if (!ra_ok) begin
                    n_status = rsme_pkg::ST_BADREG;
                end else if (st_empty) begin
                    n_status = rsme_pkg::ST_UNDER;
                end else begin
                    n_wdata  = st_rdata;
                    n_rf_we  = 1'b1;
                    n_sp_dec = 1'b1;
                end
            end else if (r_op == rsme_pkg::OP_MOV) begin
                if (!ra_ok) begin
                    n_status = rsme_pkg::ST_BADREG;
                end else begin
                    n_wdata = r_imm;
                    n_rf_we = 1'b1;
                end
            end else if (r_op >= rsme_pkg::OP_ADD && r_op <= rsme_pkg::OP_DIV) begin
                if (!ra_ok || !rb_ok) begin
                    n_status = rsme_pkg::ST_BADREG;
                end else if (r_op == rsme_pkg::OP_DIV && b_val == '0) begin
                    n_status = rsme_pkg::ST_DIVZ;
                end else if (st_full) begin
                    n_status = rsme_pkg::ST_OVER;
                end else begin
                    n_st_we = 1'b1;
                    priority if (r_op == rsme_pkg::OP_ADD) begin
                        n_wdata = a_val + b_val;
                    end else if (r_op == rsme_pkg::OP_SUB) begin
                        n_wdata = a_val - b_val;
                    end else if (r_op == rsme_pkg::OP_MUL) begin
                        n_wdata = a_val * b_val;
                    end else begin
                        n_div_start = 1'b1;
                    end
                end
            end else begin
                n_status = rsme_pkg::ST_BADOP;
            end
        end
    end

    // sequencer, commit and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rf_valid  <= '0;
            r_sp        <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && !commit) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op       <= s_axis_tdata[7:0];
                        r_ra       <= in_ra;
                        r_rb       <= in_rb;
                        r_imm      <= s_axis_tdata[55:24];
                        r_va_valid <= in_ra_ok && r_rf_valid[in_ra[RW-1:0]];
                        r_vb_valid <= in_rb_ok && r_rf_valid[in_rb[RW-1:0]];
                        r_state    <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_status <= n_status;
                    r_dvalid <= n_dvalid;
                    r_dval   <= a_val;
                    r_wdata  <= n_wdata;
                    r_rf_we  <= n_rf_we;
                    r_st_we  <= n_st_we;
                    r_sp_dec <= n_sp_dec;
                    r_state  <= n_div_start ? S_DIV : S_WB;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_wdata <= div_q;
                        r_state <= S_WB;
                    end
                end
                S_WB: begin
                    if (out_free) begin
                        if (r_rf_we) begin
                            r_rf_valid[r_ra[RW-1:0]] <= 1'b1;
                        end
                        if (r_st_we) begin
                            r_sp <= r_sp + SPW'(1);
                        end else if (r_sp_dec) begin
                            r_sp <= sp_m1;
                        end
                        if (r_status != rsme_pkg::ST_OK && r_status != rsme_pkg::ST_IGNORED) begin
                            r_halted <= 1'b1;
                        end
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_dvalid <= r_dvalid;
                        r_out_dreg   <= r_dvalid ? r_ra[4:0] : 5'd0;
                        r_out_dval   <= r_dvalid ? r_dval : '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_dval, r_out_dreg, r_out_status};
    assign m_axis_tuser  = r_out_dvalid;

endmodule

`default_nettype wire
